// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctc decoder check failed");

// next-cycle implication
`define CTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctc decoder check failed");

`endif

// ===== rtl/core/ctc_gd_pkg.sv =====
package ctc_gd_pkg;

  localparam int SCORE_W       = 16;
  localparam int LABEL_W       = 13;
  localparam int CHAR_W        = 11;
  localparam int CFG_CLASS_W   = 14;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 2;

  localparam int MAX_CLASSES_DEF = 8192;
  localparam int MAX_STEPS_DEF   = 1024;

  localparam logic [CFG_CLASS_W-1:0] CLASS_COUNT_RST = CFG_CLASS_W'(6627);
  localparam logic [CFG_CLASS_W-1:0] DICT_SIZE_RST   = CFG_CLASS_W'(6627);
  localparam logic [SCORE_W-1:0]     THRESH_RST      = '0;

  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DICT_SIZE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = CFG_IDX_W'(2);

  localparam int DIV_CNT_W = $clog2(SCORE_W);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } ctc_gd_state_t;

  typedef struct packed {
    logic step;
    logic load_step;
    logic div_start;
    logic div_step;
    logic load_div;
  } ctc_gd_cmd_t;

  typedef struct packed {
    logic result;
    logic last;
  } ctc_gd_sts_t;

endpackage

// ===== rtl/core/ctc_gd_if.sv =====
interface ctc_gd_in_if import ctc_gd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] class_score;
  logic               sequence_end;

  modport source (output valid, class_score, sequence_end, input ready);
  modport sink   (input valid, class_score, sequence_end, output ready);
endinterface

interface ctc_gd_out_if import ctc_gd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] label_index;
  logic               label_valid;
  logic               sequence_done;
  logic [SCORE_W-1:0] mean_score;
  logic [CHAR_W-1:0]  char_count;
  logic               accepted;
  logic               dictionary_error;

  modport source (output valid, label_index, label_valid, sequence_done, mean_score,
                  char_count, accepted, dictionary_error, input ready);
  modport sink   (input valid, label_index, label_valid, sequence_done, mean_score,
                  char_count, accepted, dictionary_error, output ready);
endinterface

// ===== rtl/core/ctc_greedy_decoder_unit.sv =====
// channel  | dir | payload                                              | handshake
// in_ch    | in  | class_score, sequence_end                            | valid/ready
// out_ch   | out | label_index, label_valid, sequence_done, mean_score, | valid/ready
//          |     | char_count, accepted, dictionary_error               |
// cfg_*    | in  | cfg_index, cfg_data                                  | cfg_we
//
// One score per cycle while in_ready is high; a score with no result or a label result
// keeps the unit idle, and sequence end starts the restoring mean divider (one quotient bit each step).
// in_ready drops while the divider runs or the output register is full and stalled.
// rst_n is synchronous; config registers return to defaults, sequence state clears.
module ctc_greedy_decoder_unit import ctc_gd_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int MAX_STEPS   = MAX_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ctc_gd_in_if.sink             in_ch,
  ctc_gd_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctc_gd_cmd_t cmd;
  ctc_gd_sts_t sts;

  ctc_gd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ctc_gd_dpath #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_STEPS   (MAX_STEPS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .class_score      (in_ch.class_score),
    .sequence_end     (in_ch.sequence_end),
    .cmd              (cmd),
    .sts              (sts),
    .label_index      (out_ch.label_index),
    .label_valid      (out_ch.label_valid),
    .sequence_done    (out_ch.sequence_done),
    .mean_score       (out_ch.mean_score),
    .char_count       (out_ch.char_count),
    .accepted         (out_ch.accepted),
    .dictionary_error (out_ch.dictionary_error)
  );

endmodule

// ===== rtl/core/ctc_gd_dpath.sv =====
module ctc_gd_dpath import ctc_gd_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int MAX_STEPS   = MAX_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SCORE_W-1:0]    class_score,
  input  logic                  sequence_end,
  input  ctc_gd_cmd_t           cmd,
  output ctc_gd_sts_t           sts,
  output logic [LABEL_W-1:0]    label_index,
  output logic                  label_valid,
  output logic                  sequence_done,
  output logic [SCORE_W-1:0]    mean_score,
  output logic [CHAR_W-1:0]     char_count,
  output logic                  accepted,
  output logic                  dictionary_error
);

  localparam int PW   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CMPW = ((PW > CFG_CLASS_W) ? PW : CFG_CLASS_W) + 1;
  localparam int NW   = $clog2(MAX_STEPS + 1);
  localparam int SW   = SCORE_W + NW;

  logic [CFG_CLASS_W-1:0] class_count_r, dict_size_r;
  logic [SCORE_W-1:0]     thresh_r;

  logic [PW-1:0]      pos_r, best_class_r, prev_r;
  logic [SCORE_W-1:0] best_score_r;
  logic [SW-1:0]      sum_r;
  logic [NW-1:0]      cnt_r;
  logic               err_r;

  logic [NW-1:0]      rem_r, divisor_r;
  logic [SCORE_W-1:0] quo_r;
  logic               err_h_r, lbl_valid_h_r;
  logic [PW-1:0]      lbl_idx_h_r;

  logic [CMPW-1:0]    eff;
  logic               take, step_end, candidate, dict_bad, emit;
  logic [SCORE_W-1:0] cur_score;
  logic [PW-1:0]      cur_class;
  logic [SW-1:0]      sum_nxt;
  logic [NW-1:0]      cnt_nxt;
  logic               err_nxt;
  logic [NW:0]        trial;
  logic               qbit;
  logic [NW-1:0]      rem_nxt;
  logic [SCORE_W-1:0] quo_nxt, mean_nxt;

  always_comb begin
    eff = CMPW'(class_count_r);
    if (class_count_r == '0 || CMPW'(class_count_r) > CMPW'(MAX_CLASSES)) begin
      eff = CMPW'(MAX_CLASSES);
    end
    take      = (pos_r == '0) || (class_score > best_score_r);
    cur_score = take ? class_score : best_score_r;
    cur_class = take ? pos_r : best_class_r;
    step_end  = sequence_end || (CMPW'(pos_r) + CMPW'(1) >= eff);
    candidate = step_end && !err_r && cur_class != '0 && cur_class != prev_r;
    dict_bad  = CMPW'(cur_class) >= CMPW'(dict_size_r);
    emit      = candidate && !dict_bad && (cnt_r < NW'(MAX_STEPS));
    err_nxt   = err_r || (candidate && dict_bad);
    sum_nxt   = emit ? sum_r + SW'(cur_score) : sum_r;
    cnt_nxt   = emit ? cnt_r + NW'(1) : cnt_r;
    sts.result = emit || sequence_end;
    sts.last   = sequence_end;
  end

  // restoring divider, one quotient bit per cycle while div_step is set
  always_comb begin
    trial   = {rem_r, quo_r[SCORE_W-1]};
    qbit    = trial >= {1'b0, divisor_r};
    rem_nxt = qbit ? NW'(trial - {1'b0, divisor_r}) : trial[NW-1:0];
    quo_nxt = {quo_r[SCORE_W-2:0], qbit};
    mean_nxt = (divisor_r == '0) ? '0 : quo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r <= CLASS_COUNT_RST;
      dict_size_r   <= DICT_SIZE_RST;
      thresh_r      <= THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLASS_COUNT: class_count_r <= cfg_data[CFG_CLASS_W-1:0];
        CFG_DICT_SIZE:   dict_size_r   <= cfg_data[CFG_CLASS_W-1:0];
        CFG_THRESHOLD:   thresh_r      <= cfg_data[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      best_class_r <= '0;
      best_score_r <= '0;
      prev_r       <= '0;
      sum_r        <= '0;
      cnt_r        <= '0;
      err_r        <= 1'b0;
    end else if (cmd.step) begin
      if (sequence_end) begin
        pos_r        <= '0;
        best_class_r <= '0;
        best_score_r <= '0;
        prev_r       <= '0;
        sum_r        <= '0;
        cnt_r        <= '0;
        err_r        <= 1'b0;
      end else begin
        if (step_end) begin
          pos_r        <= '0;
          best_class_r <= '0;
          best_score_r <= '0;
          prev_r       <= cur_class;
        end else begin
          pos_r        <= pos_r + PW'(1);
          best_class_r <= cur_class;
          best_score_r <= cur_score;
        end
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
        err_r <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r         <= sum_nxt[SW-1:SCORE_W];
      quo_r         <= sum_nxt[SCORE_W-1:0];
      divisor_r     <= cnt_nxt;
      err_h_r       <= err_nxt;
      lbl_valid_h_r <= emit;
      lbl_idx_h_r   <= emit ? cur_class : '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_step) begin
      label_index      <= LABEL_W'(cur_class);
      label_valid      <= 1'b1;
      sequence_done    <= 1'b0;
      mean_score       <= '0;
      char_count       <= '0;
      accepted         <= 1'b0;
      dictionary_error <= 1'b0;
    end else if (cmd.load_div) begin
      label_index      <= LABEL_W'(lbl_idx_h_r);
      label_valid      <= lbl_valid_h_r;
      sequence_done    <= 1'b1;
      mean_score       <= mean_nxt;
      char_count       <= CHAR_W'(divisor_r);
      accepted         <= mean_nxt > thresh_r;
      dictionary_error <= err_h_r;
    end
  end

endmodule

// ===== rtl/core/ctc_gd_ctrl.sv =====
module ctc_gd_ctrl import ctc_gd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  ctc_gd_sts_t sts,
  output ctc_gd_cmd_t cmd
);

  ctc_gd_state_t        state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_ready      = 1'b0;
    accept        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = !out_valid_r || out_ready;
        accept        = in_valid && in_ready;
        cmd.step      = accept;
        cmd.load_step = accept && sts.result && !sts.last;
        cmd.div_start = accept && sts.last;
        if (cmd.div_start) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end
      end
      ST_DIV: begin
        // last quotient bit waits until the output register is free
        if (cnt_r != DIV_CNT_W'(SCORE_W - 1)) begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + DIV_CNT_W'(1);
        end else if (!out_valid_r || out_ready) begin
          cmd.div_step = 1'b1;
          cmd.load_div = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.load_step || cmd.load_div) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/ctc_gd_chk.sv =====
`include "assert_macros.svh"

module ctc_gd_chk import ctc_gd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [LABEL_W-1:0] label_index,
  input logic               label_valid,
  input logic               sequence_done,
  input logic [SCORE_W-1:0] mean_score,
  input logic [CHAR_W-1:0]  char_count,
  input logic               accepted,
  input logic               dictionary_error
);

  `CTC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(label_index) && $stable(mean_score) && $stable(sequence_done))
  `CTC_ASSERT_IMP(a_no_summary, out_valid && !sequence_done, mean_score == '0 && char_count == '0 && !accepted && !dictionary_error)
  `CTC_ASSERT_IMP(a_not_empty, out_valid && !label_valid, sequence_done && label_index == '0)
  `CTC_ASSERT_IMP(a_accept_mean, out_valid && accepted, mean_score != '0)
  `CTC_ASSERT_IMP(a_zero_count, out_valid && sequence_done && char_count == '0, mean_score == '0)

endmodule

bind ctc_greedy_decoder_unit ctc_gd_chk u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .label_index      (out_ch.label_index),
  .label_valid      (out_ch.label_valid),
  .sequence_done    (out_ch.sequence_done),
  .mean_score       (out_ch.mean_score),
  .char_count       (out_ch.char_count),
  .accepted         (out_ch.accepted),
  .dictionary_error (out_ch.dictionary_error)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ctc_gd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_ITEMS  = 1050;
  localparam int unsigned OVERRUN_STEPS = 1030;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  typedef struct packed {
    logic [LABEL_W-1:0] label_index;
    logic               label_valid;
    logic               sequence_done;
    logic [SCORE_W-1:0] mean_score;
    logic [CHAR_W-1:0]  char_count;
    logic               accepted;
    logic               dictionary_error;
  } decode_result_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_CHECK
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  last;
    decode_result_t        want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ctc_gd_in_if  in_ch ();
  ctc_gd_out_if out_ch ();

  ctc_greedy_decoder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // decoder shadow: configuration and per-sequence state
  logic [CFG_CLASS_W-1:0] class_count_q;
  logic [CFG_CLASS_W-1:0] dict_size_q;
  logic [SCORE_W-1:0]     threshold_q;
  logic [LABEL_W-1:0]     position_q;
  logic [SCORE_W-1:0]     best_score_q;
  logic [LABEL_W-1:0]     best_class_q;
  logic [LABEL_W-1:0]     prev_class_q;
  logic [25:0]            score_sum_q;
  logic [CHAR_W-1:0]      char_count_q;
  logic                   dict_error_q;

  decode_result_t pending_results [$];
  stim_row_t      script [$];

  int unsigned in_run      = 0;
  int unsigned out_run     = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;
  int unsigned n_items     = 0;
  int unsigned n_results   = 0;
  int unsigned n_labels    = 0;
  int unsigned n_done      = 0;
  bit          hold_req    = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // idle cycles before the next item; occasional bursts with no idling
  function automatic int unsigned draw_gap(inout int unsigned run);
    if (run != 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      run = $urandom_range(8, 60);
      return 0;
    end
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic void add_row(input stim_row_t row);
    script.insert(script.size(), row);
  endfunction

  function automatic void clear_sequence();
    position_q   = '0;
    best_score_q = '0;
    best_class_q = '0;
    prev_class_q = '0;
    score_sum_q  = '0;
    char_count_q = '0;
    dict_error_q = 1'b0;
  endfunction

  // greedy arg-max step; returns 1 when the score produces a result
  function automatic bit decode_score(input logic [SCORE_W-1:0] score, input logic last,
                                      output decode_result_t res);
    logic [CFG_CLASS_W-1:0] span;
    logic [25:0]            mean;
    span = (class_count_q == '0 || class_count_q > CFG_CLASS_W'(MAX_CLASSES_DEF)) ?
           CFG_CLASS_W'(MAX_CLASSES_DEF) : class_count_q;
    res = '0;
    if (position_q == '0 || score > best_score_q) begin
      best_score_q = score;
      best_class_q = position_q;
    end
    if (last || CFG_CLASS_W'(position_q) + CFG_CLASS_W'(1) >= span) begin
      if (!dict_error_q && best_class_q != '0 && best_class_q != prev_class_q) begin
        if (CFG_CLASS_W'(best_class_q) >= dict_size_q) begin
          dict_error_q = 1'b1;
        end else if (char_count_q < CHAR_W'(MAX_STEPS_DEF)) begin
          score_sum_q       = score_sum_q + 26'(best_score_q);
          char_count_q      = char_count_q + 1'b1;
          res.label_index   = best_class_q;
          res.label_valid   = 1'b1;
        end
      end
      prev_class_q = best_class_q;
      position_q   = '0;
      best_score_q = '0;
      best_class_q = '0;
    end else begin
      position_q = position_q + 1'b1;
    end
    if (last) begin
      mean = (char_count_q == '0) ? '0 : score_sum_q / 26'(char_count_q);
      if (mean > 26'hFFFF) mean = 26'hFFFF;
      res.sequence_done    = 1'b1;
      res.mean_score       = mean[SCORE_W-1:0];
      res.char_count       = char_count_q;
      res.accepted         = mean[SCORE_W-1:0] > threshold_q;
      res.dictionary_error = dict_error_q;
      clear_sequence();
    end
    return res.label_valid || last;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input int unsigned value);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.data    = CFG_DATA_W'(value);
    return row;
  endfunction

  function automatic stim_row_t item_row(input int unsigned score, input logic last);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.data = CFG_DATA_W'(score);
    row.last = last;
    return row;
  endfunction

  function automatic stim_row_t check_row(input int unsigned score, input logic last,
                                          input int unsigned label, input logic done,
                                          input int unsigned mean, input int unsigned chars,
                                          input logic acc, input logic err);
    stim_row_t row;
    row                       = '0;
    row.kind                  = ROW_CHECK;
    row.data                  = CFG_DATA_W'(score);
    row.last                  = last;
    row.want.label_index      = LABEL_W'(label);
    row.want.label_valid      = (label != 0);
    row.want.sequence_done    = done;
    row.want.mean_score       = SCORE_W'(mean);
    row.want.char_count       = CHAR_W'(chars);
    row.want.accepted         = acc;
    row.want.dictionary_error = err;
    return row;
  endfunction

  task automatic put_score(input logic [SCORE_W-1:0] score, input logic last,
                           input bit typed = 1'b0, input decode_result_t want = '0);
    int unsigned    gap;
    decode_result_t res;
    gap = draw_gap(in_run);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.class_score  <= score;
    in_ch.sequence_end <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    n_items++;
    if (decode_score(score, last, res))
      pending_results.insert(pending_results.size(), typed ? want : res);
    @(negedge clk);
  endtask

  // wait for the block to go quiet, including a trailing mean division
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_CLASS_COUNT: class_count_q = data[CFG_CLASS_W-1:0];
      CFG_DICT_SIZE:   dict_size_q   = data[CFG_CLASS_W-1:0];
      CFG_THRESHOLD:   threshold_q   = data[SCORE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned    stall;
    decode_result_t want;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_gap(out_run);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      n_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: label %0d/%0d done %0d mean %0d chars %0d",
                   $time, out_ch.label_index, out_ch.label_valid, out_ch.sequence_done,
                   out_ch.mean_score, out_ch.char_count);
      end else begin
        want = pending_results.pop_front();
        check_field("label_index", want.label_index, out_ch.label_index);
        check_field("label_valid", want.label_valid, out_ch.label_valid);
        check_field("sequence_done", want.sequence_done, out_ch.sequence_done);
        check_field("mean_score", want.mean_score, out_ch.mean_score);
        check_field("char_count", want.char_count, out_ch.char_count);
        check_field("accepted", want.accepted, out_ch.accepted);
        check_field("dictionary_error", want.dictionary_error, out_ch.dictionary_error);
        if (want.label_valid) n_labels++;
        if (want.sequence_done) n_done++;
      end
      @(negedge clk);
    end
  end

  initial begin
    int unsigned        span;
    int unsigned        steps;
    int unsigned        cut;
    int unsigned        tgt;
    int unsigned        prev_tgt;
    int unsigned        peak;
    int unsigned        r;
    int unsigned        base;
    int unsigned        mark;
    bit                 noise;
    bit                 overrun_done;
    logic [SCORE_W-1:0] score;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.class_score  <= '0;
    in_ch.sequence_end <= 1'b0;
    class_count_q = CLASS_COUNT_RST;
    dict_size_q   = DICT_SIZE_RST;
    threshold_q   = THRESH_RST;
    clear_sequence();

    // reset settings: lone score closes an empty step, then one label
    add_row(check_row(100, 1'b1, 0, 1'b1, 0, 0, 1'b0, 1'b0));
    add_row(item_row(5, 1'b0));
    add_row(check_row(9, 1'b1, 1, 1'b1, 9, 1, 1'b1, 1'b0));
    add_row(cfg_row(CFG_CLASS_COUNT, 2));
    add_row(cfg_row(CFG_DICT_SIZE, 8192));
    add_row(cfg_row(CFG_THRESHOLD, 65535));
    // tie goes to the blank
    add_row(item_row(65535, 1'b0));
    add_row(item_row(65535, 1'b0));
    add_row(item_row(0, 1'b0));
    add_row(check_row(65535, 1'b0, 1, 1'b0, 0, 0, 1'b0, 1'b0));
    // repeated class suppressed; mean equal to threshold is rejected
    add_row(item_row(0, 1'b0));
    add_row(item_row(65535, 1'b0));
    add_row(check_row(65535, 1'b1, 0, 1'b1, 65535, 1, 1'b0, 1'b0));
    add_row(cfg_row(CFG_DICT_SIZE, 1));
    add_row(cfg_row(CFG_THRESHOLD, 0));
    add_row(cfg_row(CFG_SPARE, 16'hFFFF));
    // class past the dictionary latches the error and mutes the sequence
    add_row(item_row(0, 1'b0));
    add_row(item_row(7, 1'b0));
    add_row(item_row(0, 1'b0));
    add_row(item_row(9, 1'b0));
    add_row(check_row(3, 1'b1, 0, 1'b1, 0, 0, 1'b0, 1'b1));
    // zero and oversized class counts act as the maximum
    add_row(cfg_row(CFG_CLASS_COUNT, 0));
    add_row(cfg_row(CFG_DICT_SIZE, 8192));
    add_row(item_row(1, 1'b0));
    add_row(item_row(2, 1'b0));
    add_row(check_row(65535, 1'b1, 2, 1'b1, 65535, 1, 1'b1, 1'b0));
    add_row(cfg_row(CFG_CLASS_COUNT, 16383));
    add_row(item_row(0, 1'b0));
    add_row(check_row(32768, 1'b1, 1, 1'b1, 32768, 1, 1'b1, 1'b0));
    // class count lowered in the middle of a step
    add_row(cfg_row(CFG_CLASS_COUNT, 8));
    add_row(item_row(10, 1'b0));
    add_row(item_row(20, 1'b0));
    add_row(item_row(30, 1'b0));
    add_row(cfg_row(CFG_CLASS_COUNT, 2));
    add_row(item_row(5, 1'b0));
    add_row(item_row(0, 1'b1));

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_CFG: begin
          settle();
          write_reg(script[i].reg_idx, 32'(script[i].data));
        end
        ROW_ITEM: put_score(script[i].data, script[i].last);
        default:  put_score(script[i].data, script[i].last, 1'b1, script[i].want);
      endcase
    end

    hold_req     = 1'b1;
    base         = n_items;
    overrun_done = 1'b0;
    prev_tgt     = 0;
    while (n_items - base < RANDOM_ITEMS) begin
      // one long sequence past the label cap, under a long output hold-off
      if (!overrun_done && n_items - base >= RANDOM_ITEMS / 2) begin
        overrun_done = 1'b1;
        mark = n_items;
        settle();
        write_reg(CFG_CLASS_COUNT, 3);
        write_reg(CFG_DICT_SIZE, 8192);
        hold_req = 1'b1;
        for (int s = 0; s < OVERRUN_STEPS; s++) begin
          peak = $urandom_range(1, 65535);
          for (int c = 0; c < 3; c++)
            put_score((c == 1 + s % 2) ? SCORE_W'(peak) : SCORE_W'($urandom_range(0, peak - 1)),
                      1'b0);
        end
        put_score(SCORE_W'($urandom), 1'b1);
        base += n_items - mark;
      end

      settle();
      r = $urandom_range(0, 9);
      if (r == 0)
        write_reg(CFG_CLASS_COUNT, $urandom);
      else if (r == 1)
        write_reg(CFG_CLASS_COUNT, ($urandom_range(0, 1) == 0) ? 0 : 8192);
      else
        write_reg(CFG_CLASS_COUNT, $urandom_range(1, 12));
      span = (class_count_q == '0 || class_count_q > CFG_CLASS_W'(MAX_CLASSES_DEF)) ?
             MAX_CLASSES_DEF : class_count_q;
      case ($urandom_range(0, 7))
        0:       write_reg(CFG_DICT_SIZE, 1);
        1:       write_reg(CFG_DICT_SIZE, $urandom);
        2, 3:    write_reg(CFG_DICT_SIZE, $urandom_range(1, span));
        default: write_reg(CFG_DICT_SIZE, 8192);
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(CFG_THRESHOLD, 0);
        1:       write_reg(CFG_THRESHOLD, 65535);
        2:       write_reg(CFG_THRESHOLD, $urandom);
        default: write_reg(CFG_THRESHOLD, $urandom_range(0, 45000));
      endcase

      for (int q = $urandom_range(2, 6); q > 0; q--) begin
        if (span > 24) begin
          // wide steps: short sequences closed early
          cut = $urandom_range(1, 12);
          for (int c = 0; c < cut; c++) put_score(SCORE_W'($urandom), c == cut - 1);
        end else begin
          steps = $urandom_range(1, 16);
          for (int s = 0; s < steps; s++) begin
            r = $urandom_range(0, 9);
            if (span == 1 || r == 0)
              tgt = 0;
            else if (r == 1 && prev_tgt < span)
              tgt = prev_tgt;
            else
              tgt = $urandom_range(1, span - 1);
            prev_tgt = tgt;
            noise    = ($urandom_range(0, 11) == 0);
            peak     = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(1, 65535);
            cut      = span;
            if (s == steps - 1 && $urandom_range(0, 4) == 0) cut = $urandom_range(1, span);
            for (int c = 0; c < cut; c++) begin
              if (noise)
                score = SCORE_W'($urandom);
              else if (c == tgt)
                score = SCORE_W'(peak);
              else if (c < tgt)
                score = SCORE_W'($urandom_range(0, peak - 1));
              else
                score = SCORE_W'($urandom_range(0, peak));
              put_score(score, (s == steps - 1) && (c == cut - 1));
            end
          end
        end
      end
    end

    settle();
    $display("%0d scores sent, %0d results checked (%0d labels, %0d sequence summaries)",
             n_items, n_results, n_labels, n_done);
    $display("included ties, blank and repeat suppression, dictionary overflow, label cap");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ctc_gd_pkg.sv
rtl/core/ctc_gd_if.sv
rtl/core/ctc_gd_dpath.sv
rtl/core/ctc_gd_ctrl.sv
rtl/core/ctc_greedy_decoder_unit.sv
rtl/core/ctc_gd_chk.sv
verif/tb.sv
